FILE: rtl/karaoke_tag_structure_checker_top_assert.svh
// Assertion macros for the karaoke tag structure checker.
// Included by the top level; uses no package and no other header.
`ifndef KARAOKE_TAG_STRUCTURE_CHECKER_TOP_ASSERT_SVH
`define KARAOKE_TAG_STRUCTURE_CHECKER_TOP_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define KTS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define KTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kts_pkg.sv
// Shared types and character codes for the karaoke tag structure checker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package kts_pkg;

    localparam int CHAR_WIDTH = 16;

    localparam logic [CHAR_WIDTH-1:0] CH_OPEN    = 16'h007B;
    localparam logic [CHAR_WIDTH-1:0] CH_CLOSE   = 16'h007D;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_K = 16'h006B;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_K = 16'h004B;
    localparam logic [CHAR_WIDTH-1:0] CH_COMMA   = 16'h002C;
    localparam logic [CHAR_WIDTH-1:0] CH_BSLASH  = 16'h005C;

    // Position inside a tag.
    typedef enum logic [2:0] {
        PH_OUT  = 3'b001,
        PH_OPEN = 3'b010,
        PH_KTAG = 3'b100
    } tag_phase_t;

    // One input item.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  line_end;
        logic                  text_end;
    } in_item_t;

    // Result control from the core to the result register.
    typedef struct packed {
        logic valid;
        logic verdict;
    } res_ctl_t;

endpackage

FILE: rtl/kts_in_reg.sv
// Input register stage of the karaoke tag structure checker.
// Depends on kts_pkg for the item type.
`timescale 1ns / 1ps

module kts_in_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  kts_pkg::in_item_t s_item,
    input  logic             advance,
    output logic             item_valid,
    output kts_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    kts_pkg::in_item_t item_reg;
    logic              s_fire;

    // A held item leaves in the same cycle that a new one may enter.
    assign s_ready    = !valid_reg || advance;
    assign s_fire     = s_valid && s_ready;
    assign valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/kts_core.sv
// Checker state and per-item decision logic of the karaoke tag structure checker.
// Depends on kts_pkg for character codes, the tag phase and the item types.
`timescale 1ns / 1ps

module kts_core #(
    parameter int LW = 16,
    parameter int TW = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  kts_pkg::in_item_t item,
    output kts_pkg::res_ctl_t res_ctl,
    output logic [LW-1:0]     res_line,
    output logic [TW-1:0]     res_tag
);

    kts_pkg::tag_phase_t phase_reg, phase_next;
    logic [LW-1:0] line_reg, line_next;
    logic [TW-1:0] tag_reg, tag_next;
    logic [LW-1:0] open_line_reg, open_line_next;
    logic [TW-1:0] open_tag_reg, open_tag_next;
    logic          brace_reg, brace_next;
    logic          bslash_reg, bslash_next;
    logic          comma_reg, comma_next;
    logic          dcomma_reg, dcomma_next;
    logic          held_reg, held_next;
    logic [LW-1:0] held_line_reg, held_line_next;
    logic [TW-1:0] held_tag_reg, held_tag_next;
    logic          discard_reg, discard_next;

    function automatic logic [LW-1:0] sat_line(input logic [LW-1:0] v);
        return (&v) ? v : v + LW'(1);
    endfunction

    function automatic logic [TW-1:0] sat_tag(input logic [TW-1:0] v);
        return (&v) ? v : v + TW'(1);
    endfunction

    always_comb begin
        logic te;
        logic le;
        logic [kts_pkg::CHAR_WIDTH-1:0] ch;

        te = item.text_end;
        le = item.line_end || item.text_end;
        ch = item.character;

        phase_next     = phase_reg;
        line_next      = line_reg;
        tag_next       = tag_reg;
        open_line_next = open_line_reg;
        open_tag_next  = open_tag_reg;
        brace_next     = brace_reg;
        bslash_next    = bslash_reg;
        comma_next     = comma_reg;
        dcomma_next    = dcomma_reg;
        held_next      = held_reg;
        held_line_next = held_line_reg;
        held_tag_next  = held_tag_reg;
        discard_next   = discard_reg;
        res_ctl        = '0;
        res_line       = '0;
        res_tag        = '0;

        if (!discard_reg) begin
            if (ch == kts_pkg::CH_COMMA) begin
                if (comma_next) begin
                    dcomma_next = 1'b1;
                end
                comma_next = 1'b1;
            end else begin
                comma_next = 1'b0;
            end

            // A '{' must be followed directly by a backslash.
            if (!held_next && brace_next) begin
                brace_next = 1'b0;
                if (ch == kts_pkg::CH_BSLASH) begin
                    phase_next = kts_pkg::PH_OPEN;
                end else begin
                    held_next      = 1'b1;
                    held_line_next = line_next;
                    held_tag_next  = tag_next;
                end
            end

            // A backslash followed by k opens a k tag, valid only after '{'.
            if (!held_next && bslash_next) begin
                bslash_next = 1'b0;
                if (ch == kts_pkg::CH_LOWER_K || ch == kts_pkg::CH_UPPER_K) begin
                    if (phase_next != kts_pkg::PH_OPEN) begin
                        held_next      = 1'b1;
                        held_line_next = line_next;
                        held_tag_next  = tag_next;
                    end else begin
                        phase_next    = kts_pkg::PH_KTAG;
                        open_tag_next = tag_next;
                        tag_next      = sat_tag(tag_next);
                    end
                end
            end

            if (!held_next) begin
                priority if (ch == kts_pkg::CH_OPEN) begin
                    if (phase_next == kts_pkg::PH_KTAG) begin
                        held_next      = 1'b1;
                        held_line_next = open_line_next;
                        held_tag_next  = open_tag_next;
                    end else if (phase_next != kts_pkg::PH_OUT) begin
                        held_next      = 1'b1;
                        held_line_next = line_next;
                        held_tag_next  = tag_next;
                    end else begin
                        brace_next = 1'b1;
                    end
                end else if (ch == kts_pkg::CH_BSLASH) begin
                    bslash_next = 1'b1;
                end else if (ch == kts_pkg::CH_CLOSE) begin
                    if (phase_next != kts_pkg::PH_KTAG) begin
                        held_next      = 1'b1;
                        held_line_next = line_next;
                        held_tag_next  = tag_next;
                    end else begin
                        phase_next = kts_pkg::PH_OUT;
                    end
                end else begin
                end
            end

            if (le) begin
                // At the line end the lookahead character counts as none.
                if (!held_next && brace_next) begin
                    held_next      = 1'b1;
                    held_line_next = line_next;
                    held_tag_next  = tag_next;
                end
                brace_next  = 1'b0;
                bslash_next = 1'b0;

                if (!dcomma_next) begin
                    res_ctl  = '{valid: 1'b1, verdict: 1'b1};
                    res_line = line_next;
                    res_tag  = '0;
                end else if (held_next) begin
                    res_ctl  = '{valid: 1'b1, verdict: 1'b1};
                    res_line = held_line_next;
                    res_tag  = held_tag_next;
                end else begin
                    if (phase_next == kts_pkg::PH_OUT) begin
                        open_line_next = sat_line(line_next);
                    end
                    line_next   = sat_line(line_next);
                    tag_next    = TW'(1);
                    comma_next  = 1'b0;
                    dcomma_next = 1'b0;
                    if (te) begin
                        if (phase_next != kts_pkg::PH_OUT) begin
                            res_ctl  = '{valid: 1'b1, verdict: 1'b1};
                            res_line = open_line_next;
                            res_tag  = open_tag_next;
                        end else begin
                            res_ctl = '{valid: 1'b1, verdict: 1'b0};
                        end
                    end
                end
                if (res_ctl.valid && !te) begin
                    discard_next = 1'b1;
                end
            end
        end

        // The end of the text always leaves the checker ready for a new text.
        if (te && (discard_reg || res_ctl.valid)) begin
            phase_next     = kts_pkg::PH_OUT;
            line_next      = LW'(1);
            tag_next       = TW'(1);
            open_line_next = LW'(1);
            open_tag_next  = '0;
            brace_next     = 1'b0;
            bslash_next    = 1'b0;
            comma_next     = 1'b0;
            dcomma_next    = 1'b0;
            held_next      = 1'b0;
            held_line_next = '0;
            held_tag_next  = '0;
            discard_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= kts_pkg::PH_OUT;
            line_reg      <= LW'(1);
            tag_reg       <= TW'(1);
            open_line_reg <= LW'(1);
            open_tag_reg  <= '0;
            brace_reg     <= 1'b0;
            bslash_reg    <= 1'b0;
            comma_reg     <= 1'b0;
            dcomma_reg    <= 1'b0;
            held_reg      <= 1'b0;
            held_line_reg <= '0;
            held_tag_reg  <= '0;
            discard_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            line_reg      <= line_next;
            tag_reg       <= tag_next;
            open_line_reg <= open_line_next;
            open_tag_reg  <= open_tag_next;
            brace_reg     <= brace_next;
            bslash_reg    <= bslash_next;
            comma_reg     <= comma_next;
            dcomma_reg    <= dcomma_next;
            held_reg      <= held_next;
            held_line_reg <= held_line_next;
            held_tag_reg  <= held_tag_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

FILE: rtl/kts_out_reg.sv
// Result register of the karaoke tag structure checker.
// Depends on kts_pkg for the result control type.
`timescale 1ns / 1ps

module kts_out_reg #(
    parameter int LW = 16,
    parameter int TW = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  kts_pkg::res_ctl_t res_ctl,
    input  logic [LW-1:0]     res_line,
    input  logic [TW-1:0]     res_tag,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_verdict,
    output logic [LW-1:0]     m_error_line,
    output logic [TW-1:0]     m_error_tag
);

    logic          valid_reg;
    logic          valid_next;
    logic          verdict_reg;
    logic [LW-1:0] line_reg;
    logic [TW-1:0] tag_reg;
    logic          load;

    assign out_free   = !valid_reg || m_ready;
    assign load       = advance && res_ctl.valid;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= res_ctl.verdict;
            line_reg    <= res_line;
            tag_reg     <= res_tag;
        end
    end

    assign m_valid      = valid_reg;
    assign m_verdict    = verdict_reg;
    assign m_error_line = line_reg;
    assign m_error_tag  = tag_reg;

endmodule

FILE: rtl/karaoke_tag_structure_checker_top.sv
// An accepted item is held in the input register; its result is then held in the result register.
// Throughput: one item per cycle unless m_ready stalls; the core state update sets it.
// An item that causes no result leaves the block when the core takes it.
// Reset (aresetn low at a clock edge) empties both registers and returns the checker
// to line 1, tag 1, outside any tag; no clearing pass is needed.
`timescale 1ns / 1ps

module karaoke_tag_structure_checker_top #(
    parameter int LINE_NUMBER_WIDTH = 16,
    parameter int TAG_NUMBER_WIDTH  = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [15:0]                  s_character,
    input  logic                         s_line_end,
    input  logic                         s_text_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_verdict,
    output logic [LINE_NUMBER_WIDTH-1:0] m_error_line,
    output logic [TAG_NUMBER_WIDTH-1:0]  m_error_tag
);

    kts_pkg::in_item_t            s_item;
    kts_pkg::in_item_t            item;
    logic                         item_valid;
    logic                         advance;
    logic                         out_free;
    kts_pkg::res_ctl_t            res_ctl;
    logic [LINE_NUMBER_WIDTH-1:0] res_line;
    logic [TAG_NUMBER_WIDTH-1:0]  res_tag;

    assign s_item  = '{character: s_character, line_end: s_line_end, text_end: s_text_end};
    assign advance = item_valid && out_free;

    kts_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    kts_core #(
        .LW (LINE_NUMBER_WIDTH),
        .TW (TAG_NUMBER_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item),
        .res_ctl  (res_ctl),
        .res_line (res_line),
        .res_tag  (res_tag)
    );

    kts_out_reg #(
        .LW (LINE_NUMBER_WIDTH),
        .TW (TAG_NUMBER_WIDTH)
    ) u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .res_ctl      (res_ctl),
        .res_line     (res_line),
        .res_tag      (res_tag),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_error_line (m_error_line),
        .m_error_tag  (m_error_tag)
    );

`include "karaoke_tag_structure_checker_top_assert.svh"

    // A good verdict carries no position.
    `KTS_ASSERT_SAME(a_good_no_pos, aclk, aresetn, m_valid && !m_verdict, m_error_line == '0 && m_error_tag == '0, "good verdict with nonzero position")

    // Line numbers start at one and saturate, so a fault never names line zero.
    `KTS_ASSERT_SAME(a_bad_line_nonzero, aclk, aresetn, m_valid && m_verdict, m_error_line != '0, "bad verdict on line zero")

    // An item in the input register is kept until the core takes it.
    `KTS_ASSERT_NEXT(a_item_kept, aclk, aresetn, item_valid && !advance, item_valid, "input item lost while stalled")

    // A result is written only when the result register is free.
    `KTS_ASSERT_SAME(a_no_overwrite, aclk, aresetn, advance && res_ctl.valid, !m_valid || m_ready, "result register overwritten")

endmodule

FILE: dv/tb_karaoke_tag_structure_checker_top.sv
// Self-checking testbench for karaoke_tag_structure_checker_top: a directed table with its own expected
// reports, and random subtitle texts checked against an in-bench predictor.
// Depends on kts_pkg and the top level of the block only.
`timescale 1ns / 1ps

module tb_karaoke_tag_structure_checker_top;

    localparam int LINE_W      = 16;
    localparam int TAG_W       = 12;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 1700;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic              verdict;
        logic [LINE_W-1:0] line;
        logic [TAG_W-1:0]  tag;
    } report_t;

    typedef struct packed {
        logic [15:0] ch;
        logic        le;
        logic        te;
        logic        typed;
        report_t     want;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [15:0]       s_character = '0;
    logic              s_line_end = 1'b0;
    logic              s_text_end = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_verdict;
    logic [LINE_W-1:0] m_error_line;
    logic [TAG_W-1:0]  m_error_tag;

    karaoke_tag_structure_checker_top #(
        .LINE_NUMBER_WIDTH(LINE_W),
        .TAG_NUMBER_WIDTH (TAG_W)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_line_end  (s_line_end),
        .s_text_end  (s_text_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_verdict   (m_verdict),
        .m_error_line(m_error_line),
        .m_error_tag (m_error_tag)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Directed texts: each row is one character; typed rows carry their report.
    row_t dir_rows [DIR_ROWS] = '{
        // Minimal good text.
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{16'h0061,            1'b1, 1'b1, 1'b1, '{1'b0, 16'd0, 12'd0}},
        // Single character text without a double comma.
        '{16'h0061,            1'b0, 1'b1, 1'b1, '{1'b1, 16'd1, 12'd0}},
        // Complete k tag; the text ends without a line end.
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_OPEN,    1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_BSLASH,  1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_LOWER_K, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_CLOSE,   1'b0, 1'b1, 1'b1, '{1'b0, 16'd0, 12'd0}},
        // Brace not followed by a backslash.
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_OPEN,    1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{16'h0078,            1'b1, 1'b1, 1'b1, '{1'b1, 16'd1, 12'd1}},
        // Upper case tag left open over the line break until the text ends.
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_OPEN,    1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_BSLASH,  1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_UPPER_K, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{kts_pkg::CH_COMMA,   1'b0, 1'b1, 1'b1, '{1'b1, 16'd1, 12'd1}},
        // Character extremes.
        '{16'hFFFF,            1'b0, 1'b0, 1'b0, '{1'b0, 16'd0, 12'd0}},
        '{16'h0000,            1'b1, 1'b1, 1'b1, '{1'b1, 16'd1, 12'd0}},
        // Report at a line end, then the text end item is dropped.
        '{16'h0061,            1'b1, 1'b0, 1'b1, '{1'b1, 16'd1, 12'd0}},
        '{16'h0062,            1'b0, 1'b1, 1'b0, '{1'b0, 16'd0, 12'd0}}
    };

    // Predictor state.
    kts_pkg::tag_phase_t ph;
    logic [LINE_W-1:0]   line_no, open_ln, held_ln;
    logic [TAG_W-1:0]    tag_no, open_tg, held_tg;
    bit                  brace_wait, bslash_wait, prev_comma, pair_seen, fault_held, dropping;

    report_t report_q[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      burst_left = 0;
    int      rand_sent = 0;
    int      rx_tick = 0;
    int      rx_mode = 0;
    int      rx_hold = 0;

    function automatic void fmt_reset();
        ph          = kts_pkg::PH_OUT;
        line_no     = LINE_W'(1);
        tag_no      = TAG_W'(1);
        open_ln     = LINE_W'(1);
        open_tg     = '0;
        brace_wait  = 1'b0;
        bslash_wait = 1'b0;
        prev_comma  = 1'b0;
        pair_seen   = 1'b0;
        fault_held  = 1'b0;
        held_ln     = '0;
        held_tg     = '0;
        dropping    = 1'b0;
    endfunction

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] v);
        return (v == '1) ? v : v + LINE_W'(1);
    endfunction

    function automatic logic [TAG_W-1:0] tag_inc(input logic [TAG_W-1:0] v);
        return (v == '1) ? v : v + TAG_W'(1);
    endfunction

    // Only the first fault of a line is kept.
    function automatic void hold_fault(input logic [LINE_W-1:0] ln, input logic [TAG_W-1:0] tg);
        if (!fault_held) begin
            fault_held = 1'b1;
            held_ln    = ln;
            held_tg    = tg;
        end
    endfunction

    function automatic void fmt_step(input kts_pkg::in_item_t it, output bit got,
                                     output report_t rep);
        bit te;
        bit le;
        te  = it.text_end;
        le  = it.line_end | it.text_end;
        got = 1'b0;
        rep = '0;
        if (dropping) begin
            if (te) fmt_reset();
            return;
        end
        if (it.character == kts_pkg::CH_COMMA) begin
            if (prev_comma) pair_seen = 1'b1;
            prev_comma = 1'b1;
        end else begin
            prev_comma = 1'b0;
        end
        // Lookahead left open by the previous character.
        if (!fault_held && brace_wait) begin
            brace_wait = 1'b0;
            if (it.character == kts_pkg::CH_BSLASH) ph = kts_pkg::PH_OPEN;
            else hold_fault(line_no, tag_no);
        end
        if (!fault_held && bslash_wait) begin
            bslash_wait = 1'b0;
            if (it.character == kts_pkg::CH_LOWER_K || it.character == kts_pkg::CH_UPPER_K) begin
                if (ph != kts_pkg::PH_OPEN) begin
                    hold_fault(line_no, tag_no);
                end else begin
                    ph      = kts_pkg::PH_KTAG;
                    open_tg = tag_no;
                    tag_no  = tag_inc(tag_no);
                end
            end
        end
        if (!fault_held) begin
            if (it.character == kts_pkg::CH_OPEN) begin
                if (ph == kts_pkg::PH_KTAG) hold_fault(open_ln, open_tg);
                else if (ph != kts_pkg::PH_OUT) hold_fault(line_no, tag_no);
                else brace_wait = 1'b1;
            end else if (it.character == kts_pkg::CH_BSLASH) begin
                bslash_wait = 1'b1;
            end else if (it.character == kts_pkg::CH_CLOSE) begin
                if (ph != kts_pkg::PH_KTAG) hold_fault(line_no, tag_no);
                else ph = kts_pkg::PH_OUT;
            end
        end
        if (!le) return;

        // At the line end the next character counts as none.
        if (!fault_held && brace_wait) hold_fault(line_no, tag_no);
        brace_wait  = 1'b0;
        bslash_wait = 1'b0;
        got = 1'b1;
        if (!pair_seen) begin
            rep = '{1'b1, line_no, {TAG_W{1'b0}}};
        end else if (fault_held) begin
            rep = '{1'b1, held_ln, held_tg};
        end else begin
            if (ph == kts_pkg::PH_OUT) open_ln = line_inc(line_no);
            line_no    = line_inc(line_no);
            tag_no     = TAG_W'(1);
            prev_comma = 1'b0;
            pair_seen  = 1'b0;
            if (!te) begin
                got = 1'b0;
                return;
            end
            if (ph != kts_pkg::PH_OUT) rep = '{1'b1, open_ln, open_tg};
            else rep = '0;
        end
        if (te) fmt_reset();
        else dropping = 1'b1;
    endfunction

    // Drives one item in bursts with random gaps and records what it should produce.
    task automatic send(input kts_pkg::in_item_t it, input bit typed, input report_t want);
        bit      got;
        report_t rep;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid     <= 1'b1;
        s_character <= it.character;
        s_line_end  <= it.line_end;
        s_text_end  <= it.text_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        fmt_step(it, got, rep);
        if (typed) report_q.push_back(want);
        else if (got) report_q.push_back(rep);
    endtask

    function automatic logic [15:0] special_char();
        case ($urandom_range(0, 5))
            0:       return kts_pkg::CH_OPEN;
            1:       return kts_pkg::CH_CLOSE;
            2:       return kts_pkg::CH_LOWER_K;
            3:       return kts_pkg::CH_UPPER_K;
            4:       return kts_pkg::CH_COMMA;
            default: return kts_pkg::CH_BSLASH;
        endcase
    endfunction

    // Harmless text in and between tags: letters, or wide characters that exercise every bit.
    function automatic logic [15:0] filler_char();
        if ($urandom_range(0, 2) == 0) return 16'($urandom_range(16'h0100, 16'hFFFF));
        return 16'($urandom_range(16'h0061, 16'h007A));
    endfunction

    function automatic logic [15:0] noise_char();
        if ($urandom_range(0, 1) == 0) return special_char();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // One random text: mostly well formed lines, some texts with a single corrupted character,
    // and some pure noise.
    task automatic random_text();
        kts_pkg::in_item_t txt[$];
        logic [15:0]       ln[$];
        int                mode;
        int                n_lines;
        int                pieces;
        int                comma_at;
        int                idx;
        bit                in_tag;
        mode    = $urandom_range(0, 9);
        n_lines = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        in_tag  = 1'b0;
        for (int i = 0; i < n_lines; i++) begin
            ln.delete();
            if (mode >= 8) begin
                repeat ($urandom_range(1, 10)) ln.push_back(noise_char());
            end else begin
                // A tag opened on an earlier line may close here.
                if (in_tag && $urandom_range(0, 1)) begin
                    repeat ($urandom_range(0, 2)) ln.push_back(filler_char());
                    ln.push_back(kts_pkg::CH_CLOSE);
                    in_tag = 1'b0;
                end
                pieces   = $urandom_range(0, 3);
                comma_at = $urandom_range(0, pieces);
                for (int p = 0; p <= pieces; p++) begin
                    if (p == comma_at) begin
                        ln.push_back(kts_pkg::CH_COMMA);
                        ln.push_back(kts_pkg::CH_COMMA);
                    end
                    if (p == pieces) break;
                    if (in_tag || $urandom_range(0, 1)) begin
                        ln.push_back(filler_char());
                    end else begin
                        ln.push_back(kts_pkg::CH_OPEN);
                        ln.push_back(kts_pkg::CH_BSLASH);
                        ln.push_back($urandom_range(0, 1) ? kts_pkg::CH_LOWER_K
                                                          : kts_pkg::CH_UPPER_K);
                        repeat ($urandom_range(0, 2)) ln.push_back(filler_char());
                        if ($urandom_range(0, 3) != 0) ln.push_back(kts_pkg::CH_CLOSE);
                        else in_tag = 1'b1;
                    end
                end
            end
            for (int j = 0; j < ln.size(); j++) begin
                txt.push_back('{ln[j], j == ln.size() - 1, 1'b0});
            end
        end
        if (in_tag && mode < 8 && $urandom_range(0, 1)) begin
            txt.push_back('{kts_pkg::CH_CLOSE, 1'b1, 1'b0});
        end
        if (mode == 6 || mode == 7) begin
            idx = $urandom_range(0, txt.size() - 1);
            txt[idx].character = special_char();
        end
        txt[txt.size() - 1].text_end = 1'b1;
        txt[txt.size() - 1].line_end = 1'($urandom_range(0, 1));
        foreach (txt[j]) send(txt[j], 1'b0, '0);
        rand_sent += txt.size();
    endtask

    initial begin
        fmt_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send('{dir_rows[i].ch, dir_rows[i].le, dir_rows[i].te}, dir_rows[i].typed,
                 dir_rows[i].want);
        end

        while (rand_sent < RAND_ITEMS) random_text();

        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // The receiver changes its stall pattern as rx_tick advances, choosing at random among four modes.
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (rx_tick % 5 == 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 24);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("result with no report expected: verdict %0d line %0d tag %0d",
                       m_verdict, m_error_line, m_error_tag);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (m_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, m_verdict);
                    mismatches++;
                end
                if (m_error_line !== want.line) begin
                    $error("error_line: expected %0d, actual %0d", want.line, m_error_line);
                    mismatches++;
                end
                if (m_error_tag !== want.tag) begin
                    $error("error_tag: expected %0d, actual %0d", want.tag, m_error_tag);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_in_reg.sv
rtl/kts_core.sv
rtl/kts_out_reg.sv
rtl/karaoke_tag_structure_checker_top.sv
dv/tb_karaoke_tag_structure_checker_top.sv
